// File: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

// property checked only outside of reset
`define ASSERT_RUN(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`endif

// File: sv/mlta_pkg.sv
// package: constants, codes and types of the morse led tick animator
`default_nettype none
package mlta_pkg;

    localparam int FifoDepth = 32;
    localparam int PtrW      = $clog2(FifoDepth);
    localparam int CntW      = $clog2(FifoDepth + 1);
    localparam int LvlW      = 6;
    localparam int IntvW     = 16;

    localparam logic [IntvW-1:0] IntervalReset = 16'd100;
    localparam logic [IntvW-1:0] ElapsedMax    = 16'hFFFF;

    // operation codes
    localparam logic [2:0] OpTick   = 3'd0;
    localparam logic [2:0] OpDot    = 3'd1;
    localparam logic [2:0] OpDash   = 3'd2;
    localparam logic [2:0] OpSubmit = 3'd3;
    localparam logic [2:0] OpSerial = 3'd4;

    // command kinds after classification
    localparam logic [1:0] KindNone  = 2'd0;
    localparam logic [1:0] KindTick  = 2'd1;
    localparam logic [1:0] KindEvent = 2'd2;

    // command queue between front and back
    localparam int QDepth = 2;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic       lead_gap;
        logic [2:0] n_marks;
        logic [6:0] marks;    // msb first, 1 = dash
        logic [1:0] n_zeros;
    } t_cmd;

endpackage
`default_nettype wire

// File: sv/mlta_front.sv
// front: accepts input items and classifies them into beat commands
`default_nettype none
module mlta_front (
    input  wire logic         i_in_valid,
    input  wire logic [2:0]   i_operation,
    input  wire logic         i_has_mark,
    input  wire logic [1:0]   i_submit_run,
    input  wire logic [7:0]   i_encoding,
    input  wire logic         i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output mlta_pkg::t_cmd    o_cmd
);
    import mlta_pkg::*;

    logic [2:0] top_pos;
    logic [7:0] aligned;

    // position of the leading one of the serial byte
    always_comb begin
        top_pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (i_encoding[i]) begin
                top_pos = 3'(i);
            end
        end
    end

    assign aligned = 8'(i_encoding << (3'd7 - top_pos));

    always_comb begin
        o_cmd = '0;
        case (i_operation)
            OpTick: begin
                o_cmd.kind = KindTick;
            end
            OpDot, OpDash: begin
                o_cmd.kind     = KindEvent;
                o_cmd.lead_gap = i_has_mark;
                o_cmd.n_marks  = 3'd1;
                o_cmd.marks    = {(i_operation == OpDash), 6'd0};
            end
            OpSubmit: begin
                o_cmd.kind = KindEvent;
                case (i_submit_run)
                    2'd0:    o_cmd.n_zeros = 2'd3;
                    2'd1:    o_cmd.n_zeros = 2'd2;
                    default: o_cmd.n_zeros = 2'd0;
                endcase
            end
            OpSerial: begin
                // an all-zero byte queues no beats and shifts nothing, yet still gives a result
                o_cmd.kind    = (i_encoding == 8'd0) ? KindNone : KindEvent;
                o_cmd.n_marks = top_pos;
                o_cmd.marks   = aligned[6:0];
            end
            default: begin
                o_cmd.kind = KindNone;
            end
        endcase
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule
`default_nettype wire

// File: sv/mlta_cmd_queue.sv
// two-entry command queue between front and back
`default_nettype none
module mlta_cmd_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  mlta_pkg::t_cmd    i_cmd,
    input  wire logic         i_pop,
    output logic              o_full,
    output logic              o_valid,
    output mlta_pkg::t_cmd    o_cmd
);
    import mlta_pkg::*;

    t_cmd             r_q [QDepth];
    logic [QPtrW-1:0] r_wp;
    logic [QPtrW-1:0] r_rp;
    logic [QCntW-1:0] r_cnt;

    logic do_pop;

    assign o_full  = (r_cnt == QCntW'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_q[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPtrW'(QDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPtrW'(QDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// File: sv/mlta_back.sv
// back: expands commands into beats, runs the beat fifo and the led shifter
`default_nettype none
module mlta_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_valid,
    input  mlta_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    input  wire logic                   i_cfg_valid,
    input  wire logic [15:0]            i_cfg_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [7:0]                  o_light_pattern,
    output logic [5:0]                  o_queue_level,
    output logic                        o_beats_dropped
);
    import mlta_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]       r_state;
    logic [1:0]       r_kind;
    logic [6:0]       r_marks;
    logic [2:0]       r_mleft;
    logic [1:0]       r_ones;
    logic             r_gap;
    logic [1:0]       r_zeros;
    logic             r_drop;

    logic             r_mem [FifoDepth];
    logic             r_rd;
    logic [PtrW-1:0]  r_rptr;
    logic [PtrW-1:0]  r_wptr;
    logic [CntW-1:0]  r_count;
    logic [7:0]       r_pattern;
    logic [IntvW-1:0] r_elapsed;
    logic [IntvW-1:0] r_interval;

    logic             r_out_valid;
    logic [7:0]       r_out_pattern;
    logic [5:0]       r_out_level;
    logic             r_out_drop;

    logic             push_en;
    logic             push_bit;
    logic             fifo_full;
    logic [IntvW-1:0] n_elapsed;
    logic             do_shift;
    logic             out_free;

    assign fifo_full = (r_count == CntW'(FifoDepth));
    assign n_elapsed = (r_elapsed == ElapsedMax) ? r_elapsed : r_elapsed + 1'b1;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign o_pop     = (r_state == S_IDLE);

    // one beat per cycle: leading zeros, rest of a dash, gap, next mark
    always_comb begin
        push_en  = 1'b0;
        push_bit = 1'b0;
        if (r_state == S_PUSH) begin
            if (r_zeros != 2'd0) begin
                push_en = 1'b1;
            end else if (r_ones != 2'd0) begin
                push_en  = 1'b1;
                push_bit = 1'b1;
            end else if (r_gap) begin
                push_en = 1'b1;
            end else if (r_mleft != 3'd0) begin
                push_en  = 1'b1;
                push_bit = 1'b1;
            end
        end
    end

    always_comb begin
        case (r_kind)
            KindTick:  do_shift = (n_elapsed >= r_interval) && (r_count != '0);
            KindEvent: do_shift = (r_count != '0);
            default:   do_shift = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rptr     <= '0;
            r_wptr     <= '0;
            r_count    <= '0;
            r_pattern  <= '0;
            r_elapsed  <= '0;
            r_interval <= IntervalReset;
            r_drop     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_kind  <= i_cmd.kind;
                        r_marks <= i_cmd.marks;
                        r_mleft <= i_cmd.n_marks;
                        r_ones  <= 2'd0;
                        r_gap   <= i_cmd.lead_gap;
                        r_zeros <= i_cmd.n_zeros;
                        r_drop  <= 1'b0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!push_en) begin
                        r_state <= S_READ;
                    end else if (r_zeros != 2'd0) begin
                        r_zeros <= r_zeros - 1'b1;
                    end else if (r_ones != 2'd0) begin
                        r_ones <= r_ones - 1'b1;
                    end else if (r_gap) begin
                        r_gap <= 1'b0;
                    end else begin
                        r_ones  <= r_marks[6] ? 2'd2 : 2'd0;
                        r_marks <= {r_marks[5:0], 1'b0};
                        r_mleft <= r_mleft - 1'b1;
                        r_gap   <= (r_mleft > 3'd1);
                    end
                    if (push_en) begin
                        if (fifo_full) begin
                            r_drop <= 1'b1;
                        end else begin
                            r_wptr  <= (r_wptr == PtrW'(FifoDepth - 1)) ? '0 : r_wptr + 1'b1;
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                S_READ: begin
                    // head entry is read into r_rd in this cycle
                    r_state <= S_SHIFT;
                end
                S_SHIFT: begin
                    if (do_shift) begin
                        r_pattern <= {r_pattern[6:0], r_rd};
                        r_rptr    <= (r_rptr == PtrW'(FifoDepth - 1)) ? '0 : r_rptr + 1'b1;
                        r_count   <= r_count - 1'b1;
                        r_elapsed <= '0;
                    end else if (r_kind == KindTick) begin
                        r_elapsed <= n_elapsed;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en && !fifo_full) begin
            r_mem[r_wptr] <= push_bit;
        end
        r_rd <= r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_pattern <= r_pattern;
            r_out_level   <= LvlW'(r_count);
            r_out_drop    <= r_drop;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_light_pattern = r_out_pattern;
    assign o_queue_level   = r_out_level;
    assign o_beats_dropped = r_out_drop;

endmodule
`default_nettype wire

// File: sv/morse_led_tick_animator_unit.sv
// top level of the morse led tick animator
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_stall   operation, has_mark, submit_run, encoding
//  out      output     o_out_valid / i_out_stall light_pattern, queue_level, beats_dropped
//  cfg      input      i_cfg_valid / o_cfg_ready beat_interval (16 bits)
//
// in the back sequencer an item is popped, its beats (0 to 27) are pushed and a final
// push step sees the push end, then come read, shift and result
// the two-entry command queue takes new items while the back part is busy
// synchronous active-low reset; no clearing pass, fifo entries are only read once written
// a stalled result holds in the output register and the back part waits on it
`default_nettype none
module morse_led_tick_animator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic        i_has_mark,
    input  wire logic [1:0]  i_submit_run,
    input  wire logic [7:0]  i_encoding,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_light_pattern,
    output logic [5:0]       o_queue_level,
    output logic             o_beats_dropped,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);
    import mlta_pkg::*;

    t_cmd front_cmd;
    t_cmd q_cmd;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    assign o_cfg_ready = 1'b1;

    mlta_front u_front (
        .i_in_valid   (i_in_valid),
        .i_operation  (i_operation),
        .i_has_mark   (i_has_mark),
        .i_submit_run (i_submit_run),
        .i_encoding   (i_encoding),
        .i_q_full     (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    mlta_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    mlta_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_light_pattern (o_light_pattern),
        .o_queue_level   (o_queue_level),
        .o_beats_dropped (o_beats_dropped)
    );

endmodule
`default_nettype wire

// File: sv/mlta_checker.sv
// port-level checker for the morse led tick animator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module mlta_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [5:0]  o_queue_level,
    input wire logic        o_beats_dropped
);

    // a stalled result stays offered
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid)

    // the fifo never reports more than its depth
    `ASSERT_RUN(a_level_max, i_clk, i_rst_n, o_out_valid |-> (o_queue_level <= 6'd32))

    // a drop only happens on a full fifo, and the event then shifts one beat out
    `ASSERT_RUN(a_drop_level, i_clk, i_rst_n, o_out_valid && o_beats_dropped |-> (o_queue_level == 6'd31))

    // nothing is offered right after reset
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind morse_led_tick_animator_unit mlta_checker u_mlta_checker (.*);
`default_nettype wire

// File: sim/tb_morse_led_tick_animator_unit.sv
// testbench for morse_led_tick_animator_unit: directed rows, then random checked phases
`timescale 1ns / 1ps
module tb_morse_led_tick_animator_unit;
    import mlta_pkg::*;

    localparam int ResetCycles  = 6;
    localparam int PhaseCount   = 6;
    localparam int PhaseItems   = 300;
    localparam int SettleCycles = 40;
    localparam int QuietLimit   = 4000;
    localparam int BurstMax     = 110;
    localparam int RowCount     = 22;

    // operation codes the block ignores
    localparam logic [2:0] OpSpareLo  = 3'd5;
    localparam logic [2:0] OpSpareMid = 3'd6;
    localparam logic [2:0] OpSpareHi  = 3'd7;

    typedef struct packed {
        logic [7:0] pattern;
        logic [5:0] level;
        logic       dropped;
    } t_led_frame;

    typedef struct packed {
        logic [2:0] op;
        logic       mark;
        logic [1:0] run;
        logic [7:0] enc;
        logic       typed;
        t_led_frame frame;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_operation;
    logic        i_has_mark;
    logic [1:0]  i_submit_run;
    logic [7:0]  i_encoding;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_light_pattern;
    logic [5:0]  o_queue_level;
    logic        o_beats_dropped;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    morse_led_tick_animator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_has_mark     (i_has_mark),
        .i_submit_run   (i_submit_run),
        .i_encoding     (i_encoding),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_light_pattern(o_light_pattern),
        .o_queue_level  (o_queue_level),
        .o_beats_dropped(o_beats_dropped),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // animator state as predicted
    logic        beat_ring [FifoDepth];
    int unsigned head_idx    = 0;
    int unsigned tail_idx    = 0;
    int unsigned beats_held  = 0;
    logic [7:0]  led_bits    = '0;
    logic [IntvW-1:0] ticks_since = '0;
    logic [IntvW-1:0] tick_period = IntervalReset;
    logic        beat_lost   = 1'b0;

    t_led_frame  frame_q [$];
    t_script_row script_rows [RowCount];
    logic [15:0] phase_intervals [PhaseCount];

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int results_seen   = 0;
    int lossy_results  = 0;
    int tick_shifts    = 0;
    int interval_loads = 0;
    int fails          = 0;
    int quiet_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void queue_beat(input logic b);
        if (beats_held < FifoDepth) begin
            beat_ring[tail_idx] = b;
            tail_idx = (tail_idx + 1) % FifoDepth;
            beats_held++;
        end else begin
            beat_lost = 1'b1;
        end
    endfunction

    function automatic bit shift_led();
        if (beats_held == 0)
            return 1'b0;
        led_bits = {led_bits[6:0], beat_ring[head_idx]};
        head_idx = (head_idx + 1) % FifoDepth;
        beats_held--;
        ticks_since = '0;
        return 1'b1;
    endfunction

    function automatic void queue_mark(input logic dash);
        queue_beat(1'b1);
        if (dash) begin
            queue_beat(1'b1);
            queue_beat(1'b1);
        end
    endfunction

    function automatic t_led_frame animate_item(input logic [2:0] op, input logic mark,
                                                input logic [1:0] run, input logic [7:0] enc);
        t_led_frame f;
        int top;
        beat_lost = 1'b0;
        case (op)
            OpTick: begin
                if (ticks_since < ElapsedMax)
                    ticks_since++;
                if (ticks_since >= tick_period)
                    tick_shifts += shift_led();
            end
            OpDot, OpDash: begin
                if (mark)
                    queue_beat(1'b0);
                queue_mark(op == OpDash);
                void'(shift_led());
            end
            OpSubmit: begin
                if (run == 2'd0) begin
                    queue_beat(1'b0);
                    queue_beat(1'b0);
                    queue_beat(1'b0);
                end else if (run == 2'd1) begin
                    queue_beat(1'b0);
                    queue_beat(1'b0);
                end
                void'(shift_led());
            end
            OpSerial: begin
                if (enc != 8'd0) begin
                    top = 7;
                    while (!enc[top])
                        top--;
                    // marks below the leading one, gap before all but the first
                    for (int m = top - 1; m >= 0; m--) begin
                        if (m != top - 1)
                            queue_beat(1'b0);
                        queue_mark(enc[m]);
                    end
                    void'(shift_led());
                end
            end
            default: ;
        endcase
        f.pattern = led_bits;
        f.level   = 6'(beats_held);
        f.dropped = beat_lost;
        return f;
    endfunction

    task automatic drive_item(input logic [2:0] op, input logic mark, input logic [1:0] run,
                              input logic [7:0] enc, input logic typed, input t_led_frame frame);
        t_led_frame predicted;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_has_mark   <= mark;
        i_submit_run <= run;
        i_encoding   <= enc;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = animate_item(op, mark, run, enc);
        frame_q.push_back(typed ? frame : predicted);
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (frame_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic load_interval(input logic [15:0] value);
        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tick_period = value;
        interval_loads++;
    endtask

    task automatic send_random();
        int pick;
        int burst;
        logic [2:0] op;
        logic       mark;
        logic [1:0] run;
        logic [7:0] enc;
        pick = $urandom_range(99);
        mark = 1'($urandom_range(1));
        run  = 2'($urandom_range(3));
        enc  = 8'($urandom_range(255));
        if (pick < 1) begin
            // long run of ticks so that slow intervals expire too
            burst = $urandom_range(BurstMax, 1);
            repeat (burst)
                drive_item(OpTick, 1'($urandom_range(1)), 2'($urandom_range(3)),
                           8'($urandom_range(255)), 1'b0, '0);
            return;
        end
        if (pick < 35)
            op = OpTick;
        else if (pick < 47)
            op = OpDot;
        else if (pick < 59)
            op = OpDash;
        else if (pick < 69)
            op = OpSubmit;
        else if (pick < 94) begin
            op  = OpSerial;
            enc = 8'($urandom_range(255, 1));
        end else if (pick < 97) begin
            op  = OpSerial;
            enc = 8'($urandom_range(1));
        end else
            op = 3'($urandom_range(OpSpareHi, OpSpareLo));
        drive_item(op, mark, run, enc, 1'b0, '0);
    endtask

    // result checker and receiver stall
    always @(posedge i_clk) begin : check_results
        t_led_frame want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_q.size() == 0) begin
                $error("result item with nothing pending: light_pattern %h queue_level %0d",
                       o_light_pattern, o_queue_level);
                fails++;
            end else begin
                want = frame_q.pop_front();
                results_seen++;
                if (want.dropped)
                    lossy_results++;
                if (o_light_pattern !== want.pattern) begin
                    $error("light_pattern: expected %h, got %h", want.pattern, o_light_pattern);
                    fails++;
                end
                if (o_queue_level !== want.level) begin
                    $error("queue_level: expected %0d, got %0d", want.level, o_queue_level);
                    fails++;
                end
                if (o_beats_dropped !== want.dropped) begin
                    $error("beats_dropped: expected %b, got %b", want.dropped, o_beats_dropped);
                    fails++;
                end
            end
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("timeout after %0d quiet cycles, %0d items pending",
                     quiet_cycles, frame_q.size());
            $display("morse_led_tick_animator_unit verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_end;
        int halfway;
        bit paused;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_operation  = OpTick;
        i_has_mark   = 1'b0;
        i_submit_run = 2'd0;
        i_encoding   = 8'd0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = 16'd0;

        // op, has_mark, submit_run, encoding, typed, {pattern, level, dropped}
        script_rows[0]  = '{OpTick,     1'b0, 2'd0, 8'h00, 1'b1, '{8'h00, 6'd0, 1'b0}};
        script_rows[1]  = '{OpSpareLo,  1'b1, 2'd3, 8'hFF, 1'b1, '{8'h00, 6'd0, 1'b0}};
        script_rows[2]  = '{OpSpareHi,  1'b0, 2'd1, 8'h5A, 1'b1, '{8'h00, 6'd0, 1'b0}};
        script_rows[3]  = '{OpSerial,   1'b1, 2'd2, 8'h00, 1'b1, '{8'h00, 6'd0, 1'b0}};
        script_rows[4]  = '{OpSerial,   1'b0, 2'd0, 8'h01, 1'b1, '{8'h00, 6'd0, 1'b0}};
        script_rows[5]  = '{OpSubmit,   1'b0, 2'd0, 8'h00, 1'b1, '{8'h00, 6'd2, 1'b0}};
        script_rows[6]  = '{OpDot,      1'b0, 2'd0, 8'h00, 1'b0, '0};
        script_rows[7]  = '{OpDash,     1'b1, 2'd0, 8'h00, 1'b0, '0};
        script_rows[8]  = '{OpSubmit,   1'b0, 2'd1, 8'h00, 1'b0, '0};
        script_rows[9]  = '{OpSubmit,   1'b1, 2'd2, 8'h00, 1'b0, '0};
        script_rows[10] = '{OpSubmit,   1'b0, 2'd3, 8'h00, 1'b0, '0};
        script_rows[11] = '{OpSerial,   1'b0, 2'd0, 8'hFF, 1'b0, '0};
        script_rows[12] = '{OpSerial,   1'b1, 2'd3, 8'hFF, 1'b0, '0};
        script_rows[13] = '{OpSerial,   1'b0, 2'd0, 8'h80, 1'b0, '0};
        script_rows[14] = '{OpDot,      1'b1, 2'd0, 8'h00, 1'b0, '0};
        script_rows[15] = '{OpTick,     1'b1, 2'd3, 8'hFF, 1'b0, '0};
        script_rows[16] = '{OpSerial,   1'b0, 2'd0, 8'h02, 1'b0, '0};
        script_rows[17] = '{OpSerial,   1'b0, 2'd0, 8'h03, 1'b0, '0};
        script_rows[18] = '{OpSerial,   1'b0, 2'd0, 8'h55, 1'b0, '0};
        script_rows[19] = '{OpSerial,   1'b0, 2'd0, 8'hAA, 1'b0, '0};
        script_rows[20] = '{OpDash,     1'b0, 2'd0, 8'h00, 1'b0, '0};
        script_rows[21] = '{OpSpareMid, 1'b1, 2'd2, 8'h81, 1'b0, '0};

        // first phase keeps the interval from reset
        phase_intervals[0] = IntervalReset;
        phase_intervals[1] = 16'd1;
        phase_intervals[2] = 16'hFFFF;
        phase_intervals[3] = 16'd0;
        phase_intervals[4] = 16'd5;
        phase_intervals[5] = 16'd2;

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[r])
            drive_item(script_rows[r].op, script_rows[r].mark, script_rows[r].run,
                       script_rows[r].enc, script_rows[r].typed, script_rows[r].frame);

        for (int p = 0; p < PhaseCount; p++) begin
            if (p > 0)
                load_interval(phase_intervals[p]);
            send_gap_pct   = (p < 2) ? 10 : (p < 4) ? 78 : 0;
            recv_stall_pct = (p < 2) ? 78 : (p < 4) ? 10 : 0;
            phase_end = items_sent + PhaseItems;
            halfway   = items_sent + PhaseItems / 2;
            paused    = 1'b0;
            while (items_sent < phase_end) begin
                // hold the sender until the block has emptied out
                if (!paused && items_sent >= halfway) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_random();
            end
        end

        wait_drained();
        repeat (SettleCycles) @(posedge i_clk);

        $display("sent %0d items, checked %0d results, %0d of them with lost beats",
                 items_sent, results_seen, lossy_results);
        $display("%0d beats shifted by ticks over %0d interval settings, 0 and 65535 included",
                 tick_shifts, interval_loads + 1);
        if (fails == 0)
            $display("morse_led_tick_animator_unit verification clean");
        else
            $display("morse_led_tick_animator_unit verification failed");
        $finish;
    end

endmodule
